>>> hw/rtl/tpas_pkg.sv
// shared types, constants and helper functions for the pairwise axis swap address generator
package tpas_pkg;

  localparam int unsigned MAX_AXES   = 4;
  localparam int unsigned AXIS_IDX_W = $clog2(MAX_AXES);
  localparam int unsigned RANK_W     = 3;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_SIZE_ZERO  = 3'd1,
    REG_SIZE_ONE   = 3'd2,
    REG_SIZE_TWO   = 3'd3,
    REG_SIZE_THREE = 3'd4
  } reg_idx_e;

  typedef logic [MAX_AXES-1:0][DIGIT_W-1:0] digit_vec_t;
  typedef logic [MAX_AXES-1:0][ADDR_W-1:0]  stride_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0] axis_count;
    digit_vec_t        size;
  } cfg_t;

  // everything the source counter hands to the pipeline for one item
  typedef struct packed {
    digit_vec_t        digit;
    digit_vec_t        ydim;
    logic [RANK_W-1:0] rank;
    logic              last;
    logic              start;
  } entry_t;

  // axis count clamped to 1..MAX_AXES
  function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] n);
    logic [RANK_W-1:0] r;
    r = n;
    if (r == '0) r = RANK_W'(1);
    if (r > RANK_W'(MAX_AXES)) r = RANK_W'(MAX_AXES);
    return r;
  endfunction

  // zero extent counts as one
  function automatic logic [DIGIT_W-1:0] extent(input logic [DIGIT_W-1:0] s);
    return (s == '0) ? DIGIT_W'(1) : s;
  endfunction

  // pairwise swap, odd last axis stays
  function automatic logic [AXIS_IDX_W-1:0] perm(input logic [AXIS_IDX_W-1:0] i,
                                                 input logic [RANK_W-1:0]     r);
    logic [AXIS_IDX_W-1:0] p;
    p = i ^ AXIS_IDX_W'(1);
    return (RANK_W'(p) < r) ? p : i;
  endfunction

endpackage

>>> hw/rtl/tpas_cfg_regs.sv
// apb register block: axis count and the four source extents
module tpas_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpas_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tpas_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tpas_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output tpas_pkg::cfg_t                      cfg_o
);

  tpas_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_count <= tpas_pkg::RANK_W'(2);
      for (int i = 0; i < tpas_pkg::MAX_AXES; i++) begin
        cfg_q.size[i] <= tpas_pkg::DIGIT_W'(1);
      end
    end else if (wr_en) begin
      unique case (idx)
        tpas_pkg::REG_AXIS_COUNT: cfg_q.axis_count <= pwdata[tpas_pkg::RANK_W-1:0];
        tpas_pkg::REG_SIZE_ZERO:  cfg_q.size[0]    <= pwdata[tpas_pkg::DIGIT_W-1:0];
        tpas_pkg::REG_SIZE_ONE:   cfg_q.size[1]    <= pwdata[tpas_pkg::DIGIT_W-1:0];
        tpas_pkg::REG_SIZE_TWO:   cfg_q.size[2]    <= pwdata[tpas_pkg::DIGIT_W-1:0];
        tpas_pkg::REG_SIZE_THREE: cfg_q.size[3]    <= pwdata[tpas_pkg::DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      tpas_pkg::REG_AXIS_COUNT: prdata = tpas_pkg::APB_DATA_W'(cfg_q.axis_count);
      tpas_pkg::REG_SIZE_ZERO:  prdata = tpas_pkg::APB_DATA_W'(cfg_q.size[0]);
      tpas_pkg::REG_SIZE_ONE:   prdata = tpas_pkg::APB_DATA_W'(cfg_q.size[1]);
      tpas_pkg::REG_SIZE_TWO:   prdata = tpas_pkg::APB_DATA_W'(cfg_q.size[2]);
      tpas_pkg::REG_SIZE_THREE: prdata = tpas_pkg::APB_DATA_W'(cfg_q.size[3]);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/tpas_src_counter.sv
// mixed-radix source position counter and idle tracking
module tpas_src_counter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpas_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  output tpas_pkg::entry_t entry_o
);

  tpas_pkg::digit_vec_t             digit_q, digit_d;
  logic                             idle_q;
  logic [tpas_pkg::RANK_W-1:0]      rank;
  tpas_pkg::digit_vec_t             cur;
  logic [tpas_pkg::MAX_AXES-1:0]    in_use;
  logic [tpas_pkg::MAX_AXES-1:0]    full;
  logic                             last;

  assign rank = tpas_pkg::eff_rank(cfg_i.axis_count);

  always_comb begin
    logic carry;
    logic [tpas_pkg::DIGIT_W-1:0] lim;
    carry = 1'b1;
    for (int i = 0; i < tpas_pkg::MAX_AXES; i++) begin
      in_use[i] = tpas_pkg::RANK_W'(i) < rank;
      cur[i]    = in_use[i] ? digit_q[i] : '0;
      lim       = tpas_pkg::extent(cfg_i.size[i]) - tpas_pkg::DIGIT_W'(1);
      full[i]   = cur[i] >= lim;
      digit_d[i] = cur[i];
      if (in_use[i] && carry) begin
        digit_d[i] = full[i] ? '0 : cur[i] + tpas_pkg::DIGIT_W'(1);
        carry      = full[i];
      end
    end
    last = &(full | ~in_use);
  end

  // permuted extents for the destination stride products
  always_comb begin
    for (int j = 0; j < tpas_pkg::MAX_AXES; j++) begin
      if (tpas_pkg::RANK_W'(j) < rank) begin
        entry_o.ydim[j] = tpas_pkg::extent(
          cfg_i.size[tpas_pkg::perm(tpas_pkg::AXIS_IDX_W'(j), rank)]);
      end else begin
        entry_o.ydim[j] = tpas_pkg::DIGIT_W'(1);
      end
    end
  end

  assign entry_o.digit = cur;
  assign entry_o.rank  = rank;
  assign entry_o.last  = last;
  assign entry_o.start = idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      idle_q  <= 1'b1;
    end else if (accept_i) begin
      digit_q <= digit_d;
      idle_q  <= last;
    end
  end

endmodule

>>> hw/rtl/tpas_stride_unit.sv
// destination stride prefix products, latched by the first item of a tensor
module tpas_stride_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  tpas_pkg::entry_t            entry_i,
  output tpas_pkg::stride_vec_t       stride_o
);

  localparam int unsigned DW = tpas_pkg::DIGIT_W;
  localparam int unsigned AW = tpas_pkg::ADDR_W;

  // stage two
  logic                        start2_q;
  logic [AW-1:0]               p01_q;
  logic [DW-1:0]               ydim0_2_q, ydim2_2_q;
  logic [tpas_pkg::RANK_W-1:0] rank2_q;
  // stage three
  logic                        start3_q;
  logic [AW-1:0]               yst2_q, yst3_q;
  logic [DW-1:0]               ydim0_3_q;
  logic [tpas_pkg::RANK_W-1:0] rank3_q;

  tpas_pkg::stride_vec_t       stride_q;
  tpas_pkg::stride_vec_t       fresh;
  logic [2*AW-1:0]             p012;
  logic [AW-1:0]               yst [tpas_pkg::MAX_AXES];

  assign p012 = (2*AW)'(p01_q) * (2*AW)'(ydim2_2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start2_q <= 1'b0;
      start3_q <= 1'b0;
      stride_q <= '0;
    end else if (en_i) begin
      start2_q <= valid_i & entry_i.start;
      start3_q <= start2_q;
      if (start3_q) begin
        stride_q <= fresh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p01_q     <= AW'(entry_i.ydim[0]) * AW'(entry_i.ydim[1]);
      ydim0_2_q <= entry_i.ydim[0];
      ydim2_2_q <= entry_i.ydim[2];
      rank2_q   <= entry_i.rank;
      yst2_q    <= p01_q;
      yst3_q    <= p012[AW-1:0];
      ydim0_3_q <= ydim0_2_q;
      rank3_q   <= rank2_q;
    end
  end

  always_comb begin
    yst[0] = AW'(1);
    yst[1] = AW'(ydim0_3_q);
    yst[2] = yst2_q;
    yst[3] = yst3_q;
    for (int i = 0; i < tpas_pkg::MAX_AXES; i++) begin
      if (tpas_pkg::RANK_W'(i) < rank3_q) begin
        fresh[i] = yst[tpas_pkg::perm(tpas_pkg::AXIS_IDX_W'(i), rank3_q)];
      end else begin
        fresh[i] = '0;
      end
    end
  end

  // a tensor's first item uses the fresh strides, the rest the latched set
  assign stride_o = start3_q ? fresh : stride_q;

endmodule

>>> hw/rtl/tpas_addr_sum.sv
// digit times stride products, then the four-term address sum
module tpas_addr_sum (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  tpas_pkg::digit_vec_t               digit_i,
  input  tpas_pkg::stride_vec_t              stride_i,
  output logic [tpas_pkg::ADDR_W-1:0]        addr_o
);

  localparam int unsigned AW = tpas_pkg::ADDR_W;
  localparam int unsigned PW = tpas_pkg::ADDR_W + tpas_pkg::DIGIT_W;

  tpas_pkg::stride_vec_t prod_q;
  logic [AW-1:0]         sum_q;
  logic [PW-1:0]         prod [tpas_pkg::MAX_AXES];
  logic [AW-1:0]         sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < tpas_pkg::MAX_AXES; i++) begin
      prod[i] = PW'(digit_i[i]) * PW'(stride_i[i]);
      sum     = sum + prod_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < tpas_pkg::MAX_AXES; i++) begin
        prod_q[i] <= prod[i][AW-1:0];
      end
      sum_q <= sum;
    end
  end

  assign addr_o = sum_q;

endmodule

>>> hw/rtl/tensor_pairwise_axis_swap_addr.sv
// top level: transpose address generator with pairwise axis swap
//
// Elements stream in on the slave port in column-major source order (axis zero
// fastest) and leave on the master port with their linear address in the
// destination tensor, whose axes are swapped in pairs (zero with one, two with
// three; an odd last axis keeps its place). One item is accepted every cycle
// while the output side keeps up; each item goes from acceptance to the output
// register through the source counter capture, the destination stride prefix
// products (one multiply per stage), the four digit-times-stride products and
// the address sum. All stages advance together and stall only when the output
// item is not taken. The strides are computed by the first item of each tensor
// from the registers as they stand when it is accepted and held for the rest of
// that tensor; digit limits and the axis count follow the live registers. The
// last element carries tlast, after which the counter is back at zero and the
// next item starts a new tensor. Addresses wrap modulo 2^32. Registers: 0x00
// axis count (1..4, clamped), 0x04..0x10 extents of source axes zero to three
// (zero taken as one).
module tensor_pairwise_axis_swap_addr (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave item stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tpas_pkg::VALUE_W-1:0]      s_axis_tdata,   // [63:0] element_value
  // master item stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [95:0]                       m_axis_tdata,   // [31:0] dest_address,
                                                            // [95:32] out_value
  output logic                              m_axis_tlast,   // last_element
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpas_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tpas_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tpas_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned VW = tpas_pkg::VALUE_W;

  tpas_pkg::cfg_t        cfg;
  tpas_pkg::entry_t      entry;
  tpas_pkg::stride_vec_t stride;
  logic [tpas_pkg::ADDR_W-1:0] addr;

  // global pipeline advance: the output register is free or being drained
  logic en;
  logic accept;

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // payload travelling alongside the address computation
  tpas_pkg::entry_t     ent1_q;
  logic [VW-1:0]        val1_q, val2_q, val3_q, val4_q, val5_q;
  logic                 last2_q, last3_q, last4_q, last5_q;
  tpas_pkg::digit_vec_t dig2_q, dig3_q;

  assign en            = ~v5_q | m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  tpas_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpas_src_counter u_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .entry_o  (entry)
  );

  // valid bits move one stage per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (en) begin
      ent1_q  <= entry;
      val1_q  <= s_axis_tdata;
      dig2_q  <= ent1_q.digit;
      val2_q  <= val1_q;
      last2_q <= ent1_q.last;
      dig3_q  <= dig2_q;
      val3_q  <= val2_q;
      last3_q <= last2_q;
      val4_q  <= val3_q;
      last4_q <= last3_q;
      val5_q  <= val4_q;
      last5_q <= last4_q;
    end
  end

  tpas_stride_unit u_stride (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v1_q),
    .entry_i  (ent1_q),
    .stride_o (stride)
  );

  tpas_addr_sum u_sum (
    .clk_i    (clk_i),
    .en_i     (en),
    .digit_i  (dig3_q),
    .stride_i (stride),
    .addr_o   (addr)
  );

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {val5_q, addr};
  assign m_axis_tlast  = last5_q;

  // a new tensor always begins at the origin
  a_start_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry.start |-> (entry.digit == '0))
    else $error("tensor start with nonzero source digits");

  // the item after a flagged last one opens a new tensor
  a_last_then_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && entry.last) |=> entry.start)
    else $error("no tensor restart after last element");

  // the input side never waits on an empty output register
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

endmodule
